// ===== rtl/fmfc_pkg.sv =====
// fmfc_pkg: shared types and constants for the fire mode feeder controller
// used by fmfc_csr, fmfc_core and fire_mode_feeder_controller
`timescale 1ns / 1ps

package fmfc_pkg;

   localparam int unsigned SpeedWidth  = 15;
   localparam int unsigned TargetWidth = 16;
   localparam int unsigned PressWidth  = 16;
   localparam int unsigned RiseWidth   = 8;
   localparam int unsigned AngleWidth  = 13;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned CsrDataWidth = 16;
   localparam int unsigned ReqDataWidth = 40;
   localparam int unsigned RspDataWidth = 56;

   // register reset values
   localparam logic [PressWidth-1:0] LongPressReset     = 16'd1000;
   localparam logic [RiseWidth-1:0]  SingleShotReset    = 8'd5;
   localparam logic [SpeedWidth-1:0] CurrentLimitReset  = 15'd8000;
   localparam logic [SpeedWidth-1:0] FeedSpeedReset     = 15'd7200;
   localparam logic [SpeedWidth-1:0] BackoffSpeedReset  = 15'd1800;
   localparam logic [SpeedWidth-1:0] WheelSpeedReset    = 15'd8170;
   localparam logic [SpeedWidth-1:0] OverrideSpeedReset = 15'd14400;

   localparam logic [PressWidth-1:0] PressMax = '1;
   localparam logic [RiseWidth-1:0]  RiseMax  = '1;

   typedef enum logic [1:0] {
      MODE_SINGLE = 2'd0,
      MODE_CONT   = 2'd1,
      MODE_STOP   = 2'd2
   } mode_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_LONG_PRESS     = 3'd0,
      CSR_SINGLE_SHOT    = 3'd1,
      CSR_CURRENT_LIMIT  = 3'd2,
      CSR_FEED_SPEED     = 3'd3,
      CSR_BACKOFF_SPEED  = 3'd4,
      CSR_WHEEL_SPEED    = 3'd5,
      CSR_OVERRIDE_SPEED = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [PressWidth-1:0] long_press_ticks;
      logic [RiseWidth-1:0]  single_shot_rises;
      logic [SpeedWidth-1:0] current_limit;
      logic [SpeedWidth-1:0] feed_speed;
      logic [SpeedWidth-1:0] backoff_speed;
      logic [SpeedWidth-1:0] wheel_speed;
      logic [SpeedWidth-1:0] override_speed;
   } cfg_type;

   typedef struct packed {
      logic                     fire_button;
      logic [1:0]               mode_switch;
      logic [AngleWidth-1:0]    feeder_angle;
      logic signed [15:0]       feeder_current;
      logic                     force_reverse;
   } item_type;

   typedef struct packed {
      logic [PressWidth-1:0] press_ticks;
      mode_type              mode;
      logic [RiseWidth-1:0]  rise_count;
      logic [AngleWidth-1:0] prev_angle;
   } state_type;

   typedef struct packed {
      logic signed [TargetWidth-1:0] left_wheel_target;
      logic signed [TargetWidth-1:0] right_wheel_target;
      logic signed [TargetWidth-1:0] feeder_target;
      logic [1:0]                    fire_mode;
   } result_type;

endpackage

// ===== rtl/fire_mode_feeder_controller.sv =====
// fire_mode_feeder_controller: top level, input stage, tick state and result register
// depends on fmfc_pkg, fmfc_csr, fmfc_core
`timescale 1ns / 1ps
//
// channel   | direction | transfer
// ----------+-----------+-------------------------------------------------
// req_      | in        | one control tick: button, switch, angle, current
// rsp_      | out       | one result per tick: wheel and feeder targets
// csr_      | in        | one register write: index and data
//
// an accepted item is held in the input stage register, is evaluated against
// the tick state there and lands in the result register when that advances,
// which raises rsp_tvalid; one item per cycle sustained while rsp_tready
// stays high.
// the state update and the result load happen on the same edge, so the next
// item always sees the state left by the one before it.
// reset (synchronous, active high) clears the state, both stage valids and
// restores the register defaults. a stalled rsp_ side holds the result and
// the input stage; req_tready drops only when both are full and rsp_tready is low.

module fire_mode_feeder_controller
   import fmfc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // [0] fire_button, [2:1] mode_switch, [15:3] feeder_angle,
   // [31:16] feeder_current, [32] force_reverse, [39:33] zero
   input  logic [ReqDataWidth-1:0] req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // [15:0] left_wheel_target, [31:16] right_wheel_target,
   // [47:32] feeder_target, [49:48] fire_mode, [55:50] zero
   output logic [RspDataWidth-1:0] rsp_tdata,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_data
);

   cfg_type    cfg;
   item_type   req_item;
   item_type   item_ff;
   logic       item_valid_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type result_in;
   result_type result_ff;
   logic       rsp_valid_ff;
   logic       advance;

   fmfc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   fmfc_core u_core (
      .cfg        (cfg),
      .state      (state_ff),
      .item       (item_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   // unpack the request word
   assign req_item.fire_button    = req_tdata[0];
   assign req_item.mode_switch    = req_tdata[2:1];
   assign req_item.feeder_angle   = req_tdata[15:3];
   assign req_item.feeder_current = $signed(req_tdata[31:16]);
   assign req_item.force_reverse  = req_tdata[32];

   // input stage moves into the result register when that is free or draining
   assign advance    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= req_item;
      end
   end

   // tick state only moves when an item is evaluated
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.press_ticks <= '0;
         state_ff.mode        <= MODE_SINGLE;
         state_ff.rise_count  <= '0;
         state_ff.prev_angle  <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, result_ff.fire_mode, result_ff.feeder_target,
                        result_ff.right_wheel_target, result_ff.left_wheel_target};

endmodule

// ===== rtl/fmfc_csr.sv =====
// fmfc_csr: configuration register file, one write per transfer
// depends on fmfc_pkg
`timescale 1ns / 1ps

module fmfc_csr
   import fmfc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_data,
   output cfg_type                 cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_LONG_PRESS:     cfg_in.long_press_ticks  = csr_data;
            CSR_SINGLE_SHOT:    cfg_in.single_shot_rises = csr_data[RiseWidth-1:0];
            CSR_CURRENT_LIMIT:  cfg_in.current_limit     = csr_data[SpeedWidth-1:0];
            CSR_FEED_SPEED:     cfg_in.feed_speed        = csr_data[SpeedWidth-1:0];
            CSR_BACKOFF_SPEED:  cfg_in.backoff_speed     = csr_data[SpeedWidth-1:0];
            CSR_WHEEL_SPEED:    cfg_in.wheel_speed       = csr_data[SpeedWidth-1:0];
            CSR_OVERRIDE_SPEED: cfg_in.override_speed    = csr_data[SpeedWidth-1:0];
            default:            cfg_in = cfg_ff;   // unmapped index ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ticks  <= LongPressReset;
         cfg_ff.single_shot_rises <= SingleShotReset;
         cfg_ff.current_limit     <= CurrentLimitReset;
         cfg_ff.feed_speed        <= FeedSpeedReset;
         cfg_ff.backoff_speed     <= BackoffSpeedReset;
         cfg_ff.wheel_speed       <= WheelSpeedReset;
         cfg_ff.override_speed    <= OverrideSpeedReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/fmfc_core.sv =====
// fmfc_core: combinational tick update, next state and result from one item
// depends on fmfc_pkg
`timescale 1ns / 1ps

module fmfc_core
   import fmfc_pkg::*;
(
   input  cfg_type    cfg,
   input  state_type  state,
   input  item_type   item,
   output state_type  state_next,
   output result_type result
);

   logic                           rel_short;
   logic                           over_limit;
   logic [PressWidth-1:0]          press_mid;
   logic [PressWidth-1:0]          press_next;
   mode_type                       mode_sel;
   mode_type                       mode_fin;
   logic [RiseWidth-1:0]           rise_fin;
   logic                           shot_left;
   logic signed [TargetWidth-1:0]  feed_neg;
   logic signed [TargetWidth-1:0]  mode_target;
   logic signed [TargetWidth-1:0]  feeder;
   logic signed [TargetWidth:0]    cur_ext;
   logic signed [TargetWidth:0]    lim_pos;
   logic signed [TargetWidth:0]    lim_neg;
   logic signed [TargetWidth-1:0]  wheel;

   assign feed_neg = -$signed({1'b0, cfg.feed_speed});

   // press tracking and mode selection
   always_comb begin
      rel_short  = (state.press_ticks != '0) &&
                   (state.press_ticks < cfg.long_press_ticks) && !item.fire_button;
      over_limit = state.press_ticks > cfg.long_press_ticks;
      press_mid  = rel_short ? '0 : state.press_ticks;
      mode_sel   = state.mode;
      if (rel_short) begin
         mode_sel = MODE_SINGLE;
      end
      if (over_limit) begin
         mode_sel = MODE_CONT;
      end
      press_next = press_mid;
      if (item.fire_button) begin
         if (press_mid != PressMax) begin
            press_next = press_mid + 1'b1;
         end
      end else if (over_limit) begin
         press_next = '0;
         mode_sel   = MODE_STOP;
      end
   end

   // feeder target from mode, rise counting in single shot
   always_comb begin
      shot_left   = state.rise_count < cfg.single_shot_rises;
      mode_fin    = mode_sel;
      rise_fin    = state.rise_count;
      mode_target = '0;
      unique case (mode_sel)
         MODE_SINGLE: begin
            if (shot_left) begin
               mode_target = feed_neg;
               if ((item.feeder_angle > state.prev_angle) && (state.rise_count != RiseMax)) begin
                  rise_fin = state.rise_count + 1'b1;
               end
            end else begin
               mode_fin = MODE_STOP;
               rise_fin = '0;
            end
         end
         MODE_CONT: begin
            mode_target = feed_neg;
            rise_fin    = '0;
         end
         default: begin
            mode_target = '0;
            rise_fin    = '0;
         end
      endcase
   end

   // overcurrent backoff then override
   always_comb begin
      cur_ext = {item.feeder_current[TargetWidth-1], item.feeder_current};
      lim_pos = $signed({2'b00, cfg.current_limit});
      lim_neg = -lim_pos;
      feeder  = mode_target;
      priority if (item.force_reverse) begin
         feeder = -$signed({1'b0, cfg.override_speed});
      end else if (cur_ext > lim_pos) begin
         feeder = -$signed({1'b0, cfg.backoff_speed});
      end else if (cur_ext < lim_neg) begin
         feeder = $signed({1'b0, cfg.backoff_speed});
      end
   end

   assign wheel = item.mode_switch[1] ? $signed({1'b0, cfg.wheel_speed}) : '0;

   assign state_next.press_ticks = press_next;
   assign state_next.mode        = mode_fin;
   assign state_next.rise_count  = rise_fin;
   assign state_next.prev_angle  = item.feeder_angle;

   assign result.left_wheel_target  = -wheel;
   assign result.right_wheel_target = wheel;
   assign result.feeder_target      = feeder;
   assign result.fire_mode          = mode_fin;

endmodule

// ===== tb/tb_fire_mode_feeder_controller.sv =====
// tb_fire_mode_feeder_controller: self-checking bench for the fire mode feeder controller
// drives control ticks, register writes and output back-pressure, and checks every result
// against the in-bench tick model or a pinned value; depends on fmfc_pkg and the rtl top level
`timescale 1ns / 1ps

module tb_fire_mode_feeder_controller;
   import fmfc_pkg::*;

   // ------------------------------------------------------------------
   // clock, reset and dut ports, the driven ones known from time zero
   // ------------------------------------------------------------------
   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [CsrIdxWidth-1:0]  csr_index  = '0;
   logic [CsrDataWidth-1:0] csr_data   = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   fire_mode_feeder_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // ------------------------------------------------------------------
   // bench model of the controller: its own copy of registers and state
   // ------------------------------------------------------------------
   cfg_type               cfg;
   logic [PressWidth-1:0] press_cnt;
   mode_type              cur_mode;
   logic [RiseWidth-1:0]  rises_seen;
   logic [AngleWidth-1:0] prev_ang;

   // per-transfer tag: a directed row may pin the expected result by hand
   typedef struct {
      bit         pinned;
      result_type want;
   } tick_tag_type;

   typedef struct {
      item_type   it;
      bit         pinned;
      result_type want;
   } tick_row_type;

   tick_tag_type tag_q[$];
   result_type   pending_targets[$];
   tick_row_type plan[$];

   int  errors    = 0;
   bit  calm      = 1'b0;   // no idling on either side while set
   bit  hold_go   = 1'b0;   // asks the receiver for one long hold-off
   bit  hold_done = 1'b0;
   int  hold_left = 0;

   function automatic void model_reset();
      cfg.long_press_ticks  = LongPressReset;
      cfg.single_shot_rises = SingleShotReset;
      cfg.current_limit     = CurrentLimitReset;
      cfg.feed_speed        = FeedSpeedReset;
      cfg.backoff_speed     = BackoffSpeedReset;
      cfg.wheel_speed       = WheelSpeedReset;
      cfg.override_speed    = OverrideSpeedReset;
      press_cnt  = '0;
      cur_mode   = MODE_SINGLE;
      rises_seen = '0;
      prev_ang   = '0;
   endfunction

   // one control tick: button -> mode, mode -> feeder, then overcurrent, then override
   function automatic result_type step_feeder_ctrl(input item_type it);
      result_type r;
      int         cur;
      int         lim;
      int         feed;
      int         wheel;
      cur   = $signed(it.feeder_current);
      lim   = int'(cfg.current_limit);
      feed  = 0;
      wheel = 0;

      // short press released below the limit arms a single shot
      if (press_cnt != 0 && press_cnt < cfg.long_press_ticks && !it.fire_button) begin
         cur_mode  = MODE_SINGLE;
         press_cnt = '0;
      end
      if (press_cnt > cfg.long_press_ticks)
         cur_mode = MODE_CONT;
      if (it.fire_button) begin
         if (press_cnt != PressMax)
            press_cnt = press_cnt + 1'b1;
      end else if (press_cnt > cfg.long_press_ticks) begin
         press_cnt = '0;
         cur_mode  = MODE_STOP;
      end

      if (cur_mode == MODE_SINGLE) begin
         if (rises_seen < cfg.single_shot_rises)
            feed = -int'(cfg.feed_speed);
         else
            cur_mode = MODE_STOP;
         if (it.feeder_angle > prev_ang && rises_seen != RiseMax)
            rises_seen = rises_seen + 1'b1;
      end
      if (cur_mode == MODE_CONT) begin
         feed       = -int'(cfg.feed_speed);
         rises_seen = '0;
      end else if (cur_mode != MODE_SINGLE) begin
         feed       = 0;
         rises_seen = '0;
      end
      prev_ang = it.feeder_angle;

      if (cur > lim)
         feed = -int'(cfg.backoff_speed);
      else if (cur < -lim)
         feed = int'(cfg.backoff_speed);
      if (it.force_reverse)
         feed = -int'(cfg.override_speed);

      if (it.mode_switch == 2'd2 || it.mode_switch == 2'd3)
         wheel = int'(cfg.wheel_speed);

      r.left_wheel_target  = 16'(-wheel);
      r.right_wheel_target = 16'(wheel);
      r.feeder_target      = 16'(feed);
      r.fire_mode          = cur_mode;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // item builders
   // ------------------------------------------------------------------
   function automatic item_type tick_in(input bit btn, input logic [1:0] sw,
                                        input int ang, input int cur, input bit frc);
      item_type it;
      it.fire_button    = btn;
      it.mode_switch    = sw;
      it.feeder_angle   = 13'(ang);
      it.feeder_current = 16'(cur);
      it.force_reverse  = frc;
      return it;
   endfunction

   function automatic result_type tick_out(input int l, input int r, input int f,
                                           input mode_type m);
      result_type res;
      res.left_wheel_target  = 16'(l);
      res.right_wheel_target = 16'(r);
      res.feeder_target      = 16'(f);
      res.fire_mode          = m;
      return res;
   endfunction

   // current mostly around the programmed limit, sometimes anywhere
   function automatic item_type rand_tick(input bit btn, input int ang);
      int lim;
      int cur;
      int pick;
      lim  = int'(cfg.current_limit);
      pick = $urandom_range(99);
      if (pick < 55)
         cur = int'($urandom_range(2 * lim)) - lim;
      else if (pick < 80)
         cur = ($urandom_range(1) ? 1 : -1) * (lim + int'($urandom_range(2)));
      else
         cur = $urandom_range(16'hFFFF);
      return tick_in(btn, 2'($urandom_range(3)), ang, cur, $urandom_range(99) < 6);
   endfunction

   // ------------------------------------------------------------------
   // req_ side driver: one transfer per call, random gaps before it
   // ------------------------------------------------------------------
   task automatic send_tick(input item_type it, input bit pinned, input result_type want);
      tick_tag_type tag;
      tag.pinned = pinned;
      tag.want   = want;
      while (!calm && $urandom_range(99) < 28) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      tag_q.push_back(tag);
      req_tvalid <= 1'b1;
      // [0] button, [2:1] switch, [15:3] angle, [31:16] current, [32] override
      req_tdata  <= {7'd0, it.force_reverse, it.feeder_current, it.feeder_angle,
                     it.mode_switch, it.fire_button};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // register write; csr_valid stays up for back-to-back writes
   task automatic write_reg(input csr_index_type idx, input int unsigned val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= 16'(val);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_regs(input int unsigned lp, input int unsigned ssr, input int unsigned lim,
                           input int unsigned feed, input int unsigned back,
                           input int unsigned wheel, input int unsigned ovr);
      write_reg(CSR_LONG_PRESS, lp);
      write_reg(CSR_SINGLE_SHOT, ssr);
      write_reg(CSR_CURRENT_LIMIT, lim);
      write_reg(CSR_FEED_SPEED, feed);
      write_reg(CSR_BACKOFF_SPEED, back);
      write_reg(CSR_WHEEL_SPEED, wheel);
      write_reg(CSR_OVERRIDE_SPEED, ovr);
      csr_valid <= 1'b0;
   endtask

   // stop offering, wait for every expected result, then let the pipe drain
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_targets.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // random traffic made of press/fire sequences with some noise mixed in
   task automatic run_phase(input int n_items);
      int sent;
      int kind;
      int len;
      int ang;
      int lp;
      result_type none;
      sent = 0;
      ang  = $urandom_range(8191);
      none = '0;
      lp   = int'(cfg.long_press_ticks);
      while (sent < n_items) begin
         kind = $urandom_range(99);
         if (kind < 70) begin
            // press: short shot, or held around the long-press limit when that is at most 60
            if (kind < 40)
               len = $urandom_range(1, (lp > 1) ? ((lp - 1 < 20) ? lp - 1 : 20) : 1);
            else if (lp <= 60)
               len = (lp > 1) ? lp - 1 + int'($urandom_range(7)) : 1 + int'($urandom_range(7));
            else
               len = $urandom_range(1, 20);
            repeat (len) begin
               send_tick(rand_tick(1'b1, $urandom_range(8191)), 1'b0, none);
               sent++;
            end
            // release and let the feeder turn: mostly rising angles
            len = $urandom_range(1, (cfg.single_shot_rises + 3 < 300) ?
                                    cfg.single_shot_rises + 3 : 300);
            repeat (len) begin
               if ($urandom_range(99) < 85)
                  ang = (ang + int'($urandom_range(1, 60))) % 8192;
               else
                  ang = $urandom_range(8191);
               send_tick(rand_tick(1'b0, ang), 1'b0, none);
               sent++;
            end
         end else begin
            repeat ($urandom_range(1, 5)) begin
               send_tick(rand_tick(1'($urandom_range(1)), $urandom_range(8191)), 1'b0, none);
               sent++;
            end
         end
      end
   endtask

   // ------------------------------------------------------------------
   // rsp_ side: random back-pressure, one long hold-off, calm stretches
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_go && !hold_done) begin
         // sender keeps offering meanwhile, so the input stage fills and req_tready drops
         rsp_tready <= 1'b0;
         hold_left  <= 64;
         hold_done  <= 1'b1;
      end else if (calm) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= 28);
      end
   end

   // ------------------------------------------------------------------
   // checking: sample all handshakes at the edge
   // ------------------------------------------------------------------
   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         errors++;
         if (errors <= 50)
            $display("%0t mismatch %s expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      result_type   got;
      result_type   want;
      item_type     it;
      tick_tag_type tag;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_LONG_PRESS:     cfg.long_press_ticks  = csr_data;
               CSR_SINGLE_SHOT:    cfg.single_shot_rises = csr_data[RiseWidth-1:0];
               CSR_CURRENT_LIMIT:  cfg.current_limit     = csr_data[SpeedWidth-1:0];
               CSR_FEED_SPEED:     cfg.feed_speed        = csr_data[SpeedWidth-1:0];
               CSR_BACKOFF_SPEED:  cfg.backoff_speed     = csr_data[SpeedWidth-1:0];
               CSR_WHEEL_SPEED:    cfg.wheel_speed       = csr_data[SpeedWidth-1:0];
               CSR_OVERRIDE_SPEED: cfg.override_speed    = csr_data[SpeedWidth-1:0];
               default: ;
            endcase
         end

         // results first: a tick accepted at this edge cannot have its result out yet
         if (rsp_tvalid && rsp_tready) begin
            got.left_wheel_target  = rsp_tdata[15:0];
            got.right_wheel_target = rsp_tdata[31:16];
            got.feeder_target      = rsp_tdata[47:32];
            got.fire_mode          = rsp_tdata[49:48];
            if (pending_targets.size() == 0) begin
               errors++;
               if (errors <= 50)
                  $display("%0t unexpected result transfer, expected none actual %h",
                           $time, rsp_tdata);
            end else begin
               want = pending_targets.pop_front();
               check_field("left_wheel_target", $signed(want.left_wheel_target),
                           $signed(got.left_wheel_target));
               check_field("right_wheel_target", $signed(want.right_wheel_target),
                           $signed(got.right_wheel_target));
               check_field("feeder_target", $signed(want.feeder_target),
                           $signed(got.feeder_target));
               check_field("fire_mode", want.fire_mode, got.fire_mode);
            end
         end

         if (req_tvalid && req_tready) begin
            it.fire_button    = req_tdata[0];
            it.mode_switch    = req_tdata[2:1];
            it.feeder_angle   = req_tdata[15:3];
            it.feeder_current = req_tdata[31:16];
            it.force_reverse  = req_tdata[32];
            tag  = tag_q.pop_front();
            want = step_feeder_ctrl(it);
            pending_targets.push_back(tag.pinned ? tag.want : want);
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   initial begin
      result_type none;
      none = '0;
      model_reset();

      // directed table, register defaults; pinned rows can be read straight off the rules
      // idle tick after reset: single shot armed, feeder runs
      plan.push_back('{tick_in(0, 2'd0, 0, 0, 0), 1'b1, tick_out(0, 0, -7200, MODE_SINGLE)});
      // top angle, top current: wheels on, overcurrent backoff
      plan.push_back('{tick_in(0, 2'd2, 8191, 32767, 0), 1'b1,
                       tick_out(-8170, 8170, -1800, MODE_SINGLE)});
      // bottom current: backoff the other way
      plan.push_back('{tick_in(0, 2'd3, 0, -32768, 0), 1'b1,
                       tick_out(-8170, 8170, 1800, MODE_SINGLE)});
      // override beats the mode target
      plan.push_back('{tick_in(0, 2'd1, 1, 0, 1), 1'b1, tick_out(0, 0, -14400, MODE_SINGLE)});
      // current exactly at the limit, both signs: no backoff
      plan.push_back('{tick_in(0, 2'd0, 2, 8000, 0), 1'b1, tick_out(0, 0, -7200, MODE_SINGLE)});
      plan.push_back('{tick_in(0, 2'd0, 3, -8000, 0), 1'b1, tick_out(0, 0, -7200, MODE_SINGLE)});
      // one past the limit, then the shot runs out of rises and stops
      plan.push_back('{tick_in(0, 2'd0, 4, 8001, 0), 1'b0, none});
      plan.push_back('{tick_in(0, 2'd0, 5, 0, 0), 1'b0, none});
      plan.push_back('{tick_in(0, 2'd2, 6, -8001, 0), 1'b0, none});
      // short press and release rearms a single shot
      plan.push_back('{tick_in(1, 2'd0, 7, 0, 0), 1'b0, none});
      plan.push_back('{tick_in(1, 2'd1, 8, 0, 0), 1'b0, none});
      plan.push_back('{tick_in(0, 2'd0, 9, 0, 0), 1'b0, none});
      // equal and falling angles do not count as rises
      plan.push_back('{tick_in(0, 2'd0, 9, 0, 0), 1'b0, none});
      plan.push_back('{tick_in(0, 2'd3, 0, 0, 0), 1'b0, none});
      plan.push_back('{tick_in(0, 2'd0, 4096, 12345, 0), 1'b0, none});
      plan.push_back('{tick_in(0, 2'd2, 5000, -12345, 1), 1'b0, none});
      plan.push_back('{tick_in(0, 2'd0, 6000, 32767, 1), 1'b0, none});
      // all ones
      plan.push_back('{tick_in(1, 2'd3, 8191, -1, 1), 1'b0, none});
      plan.push_back('{tick_in(0, 2'd1, 8190, 1, 0), 1'b0, none});
      plan.push_back('{tick_in(0, 2'd0, 8191, -32767, 0), 1'b0, none});

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i])
         send_tick(plan[i].it, plan[i].pinned, plan[i].want);
      settle();

      // lowest settings; the long hold-off on the result side happens in this phase
      set_regs(1, 1, 0, 0, 0, 0, 0);
      hold_go <= 1'b1;
      run_phase(80);
      settle();

      // highest settings: long single shots that saturate the rise count
      set_regs(65534, 255, 32767, 32767, 32767, 32767, 32767);
      run_phase(150);

      // long press stretch with no idling on either side, then release
      calm = 1'b1;
      repeat (100)
         send_tick(rand_tick(1'b1, $urandom_range(8191)), 1'b0, none);
      repeat (5)
         send_tick(rand_tick(1'b0, $urandom_range(8191)), 1'b0, none);
      calm = 1'b0;
      settle();

      // random settings with short long-press limits
      repeat (4) begin
         set_regs($urandom_range(1, 30), $urandom_range(1, 12), $urandom_range(32767),
                  $urandom_range(32767), $urandom_range(32767), $urandom_range(32767),
                  $urandom_range(32767));
         run_phase(60);
         settle();
      end

      // back to the reset defaults for a last stretch
      set_regs(LongPressReset, SingleShotReset, CurrentLimitReset, FeedSpeedReset,
               BackoffSpeedReset, WheelSpeedReset, OverrideSpeedReset);
      run_phase(40);
      settle();

      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/fmfc_pkg.sv
rtl/fmfc_csr.sv
rtl/fmfc_core.sv
rtl/fire_mode_feeder_controller.sv
tb/tb_fire_mode_feeder_controller.sv
